// File: rtl/core/tcc_pkg.sv
// tcc_pkg: shared types and constants for the threshold coordinate clusterer
// holds the item and result word structs, controller states and the
// command and status groups between controller and datapath; no dependencies
package tcc_pkg;

	localparam int COORD_W = 31;
	localparam int TAG_W   = 16;

	// one input word
	typedef struct packed {
		logic [COORD_W-1:0] coord;
		logic [TAG_W-1:0]   item_tag;
		logic               reverse_strand;
		logic               last_item;
	} item_t;

	// one result word
	typedef struct packed {
		logic [COORD_W-1:0] rep_coord;
		logic [TAG_W-1:0]   seed_tag;
		logic               overflow;
		logic               last_result;
	} result_t;

	// controller states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SEED_RD,
		ST_SEED_CHK,
		ST_SCAN,
		ST_SCAN_END,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // store the accepted item word
		logic seed_rd;     // read stores at seed index
		logic seed_inc;    // advance seed index
		logic seed_start;  // latch seed, start a candidate scan
		logic cand_rd;     // read stores at candidate index, advance it
		logic emit;        // load the result register
		logic clr_set;     // return set state to empty
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic taken;       // registered taken flag of the last read
		logic seed_last;   // seed index is the final stored entry
		logic cand_last;   // candidate index is the final stored entry
		logic more_left;   // some later entry stayed out of this cluster
		logic out_free;    // result register can take a word
	} sts_t;

endpackage

// File: rtl/core/tcc_ctrl.sv
// tcc_ctrl: sequencer for loading, seed search, candidate scan and result emit
// depends on tcc_pkg for the state enum and the command/status structs
module tcc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          item_last,
	output logic          item_ready,
	input  tcc_pkg::sts_t sts,
	output tcc_pkg::cmd_t cmd
);

	tcc_pkg::state_t state_q;
	tcc_pkg::state_t state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcc_pkg::ST_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			tcc_pkg::ST_LOAD: begin
				if (item_valid && item_last) begin
					state_nx = tcc_pkg::ST_SEED_RD;
				end
			end
			tcc_pkg::ST_SEED_RD: begin
				state_nx = tcc_pkg::ST_SEED_CHK;
			end
			tcc_pkg::ST_SEED_CHK: begin
				if (sts.taken) begin
					state_nx = tcc_pkg::ST_SEED_RD;
				end else if (sts.seed_last) begin
					state_nx = tcc_pkg::ST_EMIT;
				end else begin
					state_nx = tcc_pkg::ST_SCAN;
				end
			end
			tcc_pkg::ST_SCAN: begin
				if (sts.cand_last) begin
					state_nx = tcc_pkg::ST_SCAN_END;
				end
			end
			tcc_pkg::ST_SCAN_END: begin
				state_nx = tcc_pkg::ST_EMIT;
			end
			tcc_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					state_nx = sts.more_left ? tcc_pkg::ST_SEED_RD : tcc_pkg::ST_LOAD;
				end
			end
			default: begin
				state_nx = tcc_pkg::ST_LOAD;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			tcc_pkg::ST_LOAD: begin
				item_ready = 1'b1;
				cmd.load   = item_valid;
			end
			tcc_pkg::ST_SEED_RD: begin
				cmd.seed_rd = 1'b1;
			end
			tcc_pkg::ST_SEED_CHK: begin
				if (sts.taken) begin
					cmd.seed_inc = 1'b1;
				end else begin
					cmd.seed_start = 1'b1;
				end
			end
			tcc_pkg::ST_SCAN: begin
				cmd.cand_rd = 1'b1;
			end
			tcc_pkg::ST_SCAN_END: begin
				cmd = '0;
			end
			tcc_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.seed_inc = sts.more_left;
					cmd.clr_set  = !sts.more_left;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: rtl/core/tcc_dp.sv
// tcc_dp: coordinate, tag and taken stores, distance compare and result register
// depends on tcc_pkg for word types and the command/status structs
module tcc_dp #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcc_pkg::cmd_t                cmd,
	output tcc_pkg::sts_t                sts,
	input  tcc_pkg::item_t               item,
	input  logic                         cfg_we,
	input  logic [tcc_pkg::COORD_W-1:0]  cfg_data,
	output logic                         result_valid,
	input  logic                         result_ready,
	output tcc_pkg::result_t             result
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);

	// stores
	logic [tcc_pkg::COORD_W-1:0] coord_mem [MAX_ITEMS];
	logic [tcc_pkg::TAG_W-1:0]   tag_mem   [MAX_ITEMS];
	logic                        taken_mem [MAX_ITEMS];

	// set and scan state
	logic [CW-1:0]               cnt_q;
	logic                        strand_q;
	logic                        drop_q;
	logic [tcc_pkg::COORD_W-1:0] dist_q;
	logic [AW-1:0]               seed_q;
	logic [AW-1:0]               cand_q;
	logic [tcc_pkg::COORD_W-1:0] seedc_q;
	logic [tcc_pkg::COORD_W-1:0] rep_q;
	logic [tcc_pkg::TAG_W-1:0]   stag_q;
	logic                        left_q;

	// registered read data
	logic [tcc_pkg::COORD_W-1:0] coord_rd_q;
	logic [tcc_pkg::TAG_W-1:0]   tag_rd_q;
	logic                        taken_rd_q;

	// candidate evaluation stage
	logic                        evl_s1;
	logic [AW-1:0]               idx_s1;

	// result register
	logic                        result_valid_q;
	tcc_pkg::result_t            result_q;

	logic                        ren;
	logic [AW-1:0]               raddr;
	logic                        store_ok;
	logic                        tk_we;
	logic [AW-1:0]               tk_addr;
	logic                        tk_data;
	logic [tcc_pkg::COORD_W-1:0] diff;
	logic                        near;
	logic                        better;
	logic                        join_c;
	logic                        stay_c;

	assign store_ok = (cnt_q < CNT_MAX);
	assign ren      = cmd.seed_rd || cmd.cand_rd;
	assign raddr    = cmd.seed_rd ? seed_q : cand_q;

	// distance between seed and candidate, strand-dependent extreme
	assign diff   = (coord_rd_q >= seedc_q) ? (coord_rd_q - seedc_q) : (seedc_q - coord_rd_q);
	assign near   = (diff < dist_q);
	assign better = strand_q ? (coord_rd_q > rep_q) : (coord_rd_q < rep_q);
	assign join_c = evl_s1 && !taken_rd_q && near;
	assign stay_c = evl_s1 && !taken_rd_q && !near;

	// taken store write: cleared on load, set when a candidate joins
	assign tk_we   = (cmd.load && store_ok) || join_c;
	assign tk_addr = join_c ? idx_s1 : cnt_q[AW-1:0];
	assign tk_data = join_c;

	// coordinate and tag stores
	always_ff @(posedge clk) begin
		if (cmd.load && store_ok) begin
			coord_mem[cnt_q[AW-1:0]] <= item.coord;
			tag_mem[cnt_q[AW-1:0]]   <= item.item_tag;
		end
		if (ren) begin
			coord_rd_q <= coord_mem[raddr];
			tag_rd_q   <= tag_mem[raddr];
		end
	end

	// taken store
	always_ff @(posedge clk) begin
		if (tk_we) begin
			taken_mem[tk_addr] <= tk_data;
		end
		if (ren) begin
			taken_rd_q <= taken_mem[raddr];
		end
	end

	// distance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
		end else if (cfg_we) begin
			dist_q <= cfg_data;
		end
	end

	// set count, strand and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			strand_q <= 1'b0;
			drop_q   <= 1'b0;
		end else if (cmd.clr_set) begin
			cnt_q    <= '0;
			strand_q <= 1'b0;
			drop_q   <= 1'b0;
		end else if (cmd.load) begin
			if (cnt_q == '0) begin
				strand_q <= item.reverse_strand;
			end
			if (store_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	// seed and candidate indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			cand_q <= '0;
		end else begin
			if (cmd.clr_set) begin
				seed_q <= '0;
			end else if (cmd.seed_inc) begin
				seed_q <= seed_q + AW'(1);
			end
			if (cmd.seed_start) begin
				cand_q <= seed_q + AW'(1);
			end else if (cmd.cand_rd) begin
				cand_q <= cand_q + AW'(1);
			end
		end
	end

	// evaluation stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evl_s1 <= 1'b0;
			left_q <= 1'b0;
		end else begin
			evl_s1 <= cmd.cand_rd;
			if (cmd.seed_start) begin
				left_q <= 1'b0;
			end else if (stay_c) begin
				left_q <= 1'b1;
			end
		end
	end

	// seed capture and representative update
	always_ff @(posedge clk) begin
		idx_s1 <= cand_q;
		if (cmd.seed_start) begin
			seedc_q <= coord_rd_q;
			rep_q   <= coord_rd_q;
			stag_q  <= tag_rd_q;
		end else if (join_c && better) begin
			rep_q <= coord_rd_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.rep_coord   <= rep_q;
			result_q.seed_tag    <= stag_q;
			result_q.overflow    <= drop_q;
			result_q.last_result <= !left_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// status
	assign sts.taken     = taken_rd_q;
	assign sts.seed_last = ((CW'(seed_q) + CW'(1)) == cnt_q);
	assign sts.cand_last = ((CW'(cand_q) + CW'(1)) == cnt_q);
	assign sts.more_left = left_q;
	assign sts.out_free  = !result_valid_q || result_ready;

endmodule

// File: rtl/core/threshold_coordinate_clusterer.sv
// threshold_coordinate_clusterer: top level joining controller and datapath
// depends on tcc_pkg, tcc_ctrl and tcc_dp
//
//  channel  | direction | handshake                   | word
//  ---------+-----------+-----------------------------+------------------
//  item     | in        | item_valid / item_ready     | tcc_pkg::item_t
//  result   | out       | result_valid / result_ready | tcc_pkg::result_t
//  cfg      | in        | cfg_we (no wait)            | cluster_distance
//
// loading takes one cycle per word; the word flagged last starts clustering
// clustering reads and checks each seed position in turn, skipping taken seeds;
// behind an untaken seed each later word is read as a candidate, and then the
// cluster is emitted (at once for a final-word seed), all over one store read port
// item_ready is low from the last word until the final result is in the
// result register; a stalled result holds the sequencer in its emit step
// reset is asynchronous active low; the stores need no clearing pass
module threshold_coordinate_clusterer #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  tcc_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output tcc_pkg::result_t            result,
	input  logic                        cfg_we,
	input  logic [tcc_pkg::COORD_W-1:0] cfg_data
);

	tcc_pkg::cmd_t cmd;
	tcc_pkg::sts_t sts;

	// sequencer
	tcc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_last  (item.last_item),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// stores and compare
	tcc_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: rtl/core/tcc_chk.sv
// tcc_chk: port-level checks for the threshold coordinate clusterer
// depends on tcc_pkg; bound to the top level at the end of this file
module tcc_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_ready,
	input tcc_pkg::item_t              item,
	input logic                        result_valid,
	input logic                        result_ready,
	input tcc_pkg::result_t            result
);

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// no new word is taken once the last word of a set is in
	a_last_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.last_item |=> !item_ready)
		else $error("item taken right after the last word of a set");

	// while a non-final result waits, the set is still clustering
	a_mid_set_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_result |-> !item_ready)
		else $error("item_ready high during clustering");

endmodule

bind threshold_coordinate_clusterer tcc_chk u_tcc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
